// ----- hdl/afca_pkg.sv -----
package afca_pkg;

    // Framing characters
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_ETX = 8'h03;

    // Packet identifiers
    localparam logic [7:0] ID_HEAD   = 8'h3C; // '<'
    localparam logic [7:0] ID_RESULT = 8'h3B; // ';'
    localparam logic [7:0] ID_END    = 8'h3A; // ':'
    localparam logic [7:0] ID_REPEAT = 8'h3F; // '?'

    // ASCII hex digit decoding
    localparam logic [7:0] DIGIT_BASE   = 8'h30;
    localparam logic [7:0] DIGIT_LETTER = 8'h37;
    localparam logic [7:0] DIGIT_NINE   = 8'h39;

    typedef enum logic [1:0] {
        ACK_NONE = 2'd0,
        ACK_REP  = 2'd1,
        ACK_MOR  = 2'd2
    } ack_kind_t;

    typedef enum logic [2:0] {
        FRAME_HEAD   = 3'd0,
        FRAME_RESULT = 3'd1,
        FRAME_END    = 3'd2,
        FRAME_REPEAT = 3'd3,
        FRAME_OTHER  = 3'd4
    } frame_kind_t;

    typedef enum logic [1:0] {
        CHECK_MATCH    = 2'd0,
        CHECK_SKIPPED  = 2'd1,
        CHECK_MISMATCH = 2'd2,
        CHECK_NO_ETX   = 2'd3
    } check_status_t;

    // One verdict item, first field in the highest bits
    typedef struct packed {
        logic [7:0]    function_code;
        check_status_t check_status;
        frame_kind_t   frame_kind;
        ack_kind_t     ack_kind;
    } verdict_t;

    // Map a packet identifier to its frame kind
    function automatic frame_kind_t kind_of(input logic [7:0] id);
        frame_kind_t k;
        unique case (id)
            ID_HEAD:   k = FRAME_HEAD;
            ID_RESULT: k = FRAME_RESULT;
            ID_END:    k = FRAME_END;
            ID_REPEAT: k = FRAME_REPEAT;
            default:   k = FRAME_OTHER;
        endcase
        return k;
    endfunction

    // Decode one ASCII hex digit; any byte is decoded by the same rule
    function automatic logic [7:0] decode_digit(input logic [7:0] b);
        logic [7:0] d;
        if (b > DIGIT_NINE)
        begin
            d = b - DIGIT_LETTER;
        end
        else
        begin
            d = b - DIGIT_BASE;
        end
        return d;
    endfunction

endpackage

// ----- hdl/analyzer_frame_check_and_ack.sv -----
// Frame check and acknowledge for a serial instrument link. Each input item is
// one received byte; a CR closes the frame and yields one verdict item holding
// the acknowledge to send, the frame kind, the checksum status and the
// function code. The block takes one byte every cycle unless it stalls: a byte
// passes through an input register, then updates the frame state and, for a CR,
// loads the output register at the same clock edge; the verdict is offered there.
// Input stalls only while a CR sits in the input register and the previous
// verdict has not yet been taken from the output register. Bytes at offset
// MAX_FRAME and beyond are ignored until the CR.
module analyzer_frame_check_and_ack
    import afca_pkg::*;
#(
    parameter int MAX_FRAME = 512
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [1:0] ack_kind, [4:2] frame_kind,
                                   // [6:5] check_status, [14:7] function_code,
                                   // [15] zero
);

    localparam int PW = $clog2(MAX_FRAME + 1);
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_FRAME);
    localparam logic [PW-1:0] POS_ID  = PW'(1);
    localparam logic [PW-1:0] POS_FN  = PW'(2);

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Frame state
    logic [PW-1:0] pos_reg, pos_next;
    logic [7:0]    sum_reg, sum_next;
    logic          etx_reg, etx_next;
    logic [1:0]    digits_reg, digits_next;
    logic [7:0]    rx_sum_reg, rx_sum_next;
    logic [7:0]    id_reg, id_next;
    logic [7:0]    fn_reg, fn_next;
    ack_kind_t     last_ack_reg, last_ack_next;

    // Output register
    logic     out_valid_reg;
    verdict_t out_reg;
    verdict_t verdict;

    logic is_cr;
    logic out_free;
    logic advance;
    logic [7:0] digit;
    frame_kind_t kind;
    check_status_t status;
    ack_kind_t ack;

    // Handshake: the input register moves on unless a CR meets a full output that is not taken
    assign is_cr    = (in_byte_reg == CH_CR);
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!is_cr || out_free);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg};

    // Verdict for the frame closed by a CR
    assign kind  = kind_of(id_reg);
    assign digit = decode_digit(in_byte_reg);

    always_comb
    begin
        if (!etx_reg)
        begin
            status = CHECK_NO_ETX;
        end
        else if (sum_reg == 8'd0)
        begin
            status = CHECK_SKIPPED;
        end
        else if (sum_reg == rx_sum_reg)
        begin
            status = CHECK_MATCH;
        end
        else
        begin
            status = CHECK_MISMATCH;
        end

        last_ack_next = last_ack_reg;
        if (status == CHECK_MISMATCH || status == CHECK_NO_ETX)
        begin
            ack           = ACK_REP;
            last_ack_next = ACK_REP;
        end
        else if (kind == FRAME_HEAD || kind == FRAME_RESULT)
        begin
            ack           = ACK_MOR;
            last_ack_next = ACK_MOR;
        end
        else if (kind == FRAME_REPEAT)
        begin
            ack = (last_ack_reg == ACK_MOR) ? ACK_MOR : ACK_REP;
        end
        else
        begin
            ack = ACK_NONE;
        end

        verdict.ack_kind      = ack;
        verdict.frame_kind    = kind;
        verdict.check_status  = status;
        verdict.function_code = fn_reg;
    end

    // Frame state update for an ordinary byte
    always_comb
    begin
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        etx_next    = etx_reg;
        digits_next = digits_reg;
        rx_sum_next = rx_sum_reg;
        id_next     = id_reg;
        fn_next     = fn_reg;
        if (pos_reg < POS_MAX)
        begin
            if (pos_reg == POS_ID)
            begin
                id_next = in_byte_reg;
            end
            if (pos_reg == POS_FN)
            begin
                fn_next = in_byte_reg;
            end
            if (pos_reg >= POS_ID)
            begin
                if (!etx_reg)
                begin
                    if (pos_reg >= POS_FN && in_byte_reg == CH_ETX)
                    begin
                        etx_next = 1'b1;
                    end
                    else
                    begin
                        sum_next = sum_reg + in_byte_reg;
                    end
                end
                else if (digits_reg < 2'd2)
                begin
                    if (digits_reg == 2'd0)
                    begin
                        rx_sum_next = {digit[3:0], 4'h0};
                    end
                    else
                    begin
                        rx_sum_next = rx_sum_reg + digit;
                    end
                    digits_next = digits_reg + 2'd1;
                end
            end
            pos_next = pos_reg + POS_ID;
        end
    end

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    // Frame state registers; a CR clears all but the last acknowledge
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            sum_reg      <= 8'd0;
            etx_reg      <= 1'b0;
            digits_reg   <= 2'd0;
            rx_sum_reg   <= 8'd0;
            id_reg       <= 8'd0;
            fn_reg       <= 8'd0;
            last_ack_reg <= ACK_NONE;
        end
        else if (advance)
        begin
            if (is_cr)
            begin
                pos_reg      <= '0;
                sum_reg      <= 8'd0;
                etx_reg      <= 1'b0;
                digits_reg   <= 2'd0;
                rx_sum_reg   <= 8'd0;
                id_reg       <= 8'd0;
                fn_reg       <= 8'd0;
                last_ack_reg <= last_ack_next;
            end
            else
            begin
                pos_reg    <= pos_next;
                sum_reg    <= sum_next;
                etx_reg    <= etx_next;
                digits_reg <= digits_next;
                rx_sum_reg <= rx_sum_next;
                id_reg     <= id_next;
                fn_reg     <= fn_next;
            end
        end
    end

    // Output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && is_cr)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (advance && is_cr)
        begin
            out_reg <= verdict;
        end
    end

`ifndef SYNTHESIS
    // The input side only stalls on a CR waiting for a full output register
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && is_cr && out_valid_reg && !m_tready))
        else $error("input stalled without a pending verdict");

    // A CR that moves on always leaves a verdict in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && is_cr) |=> out_valid_reg)
        else $error("verdict lost after CR");

    // A failed check never answers MOR or nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_reg.check_status == CHECK_MISMATCH ||
                      out_reg.check_status == CHECK_NO_ETX))
        |-> (out_reg.ack_kind == ACK_REP))
        else $error("failed check without resend request");

    // The byte position never passes the frame limit
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_MAX)
        else $error("byte position beyond frame limit");

    // Received digits are only counted once ETX has been seen
    assert property (@(posedge clk) disable iff (!rst_n)
        (digits_reg != 2'd0) |-> etx_reg)
        else $error("digits counted before ETX");
`endif

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    import afca_pkg::*;

    localparam int FRAME_LIMIT  = 512;
    localparam int RANDOM_ITEMS = 1500;
    localparam int HOLD_CYCLES  = 80;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [7:0] CH_STX = 8'h02;

    typedef struct {
        logic [7:0] rx;
        bit         pinned;
        verdict_t   want;
    } directed_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    // Frame state mirrored by the verdict predictor.
    int            fr_pos    = 0;
    logic [7:0]    fr_sum    = '0;
    bit            fr_etx    = 1'b0;
    int            fr_digits = 0;
    logic [7:0]    fr_rsum   = '0;
    logic [7:0]    fr_id     = '0;
    logic [7:0]    fr_fn     = '0;
    ack_kind_t     prev_ack  = ACK_NONE;

    verdict_t      verdict_q [$];
    directed_row_t directed_rows [$];
    logic [7:0]    frame_bytes [$];

    int errors      = 0;
    int bytes_sent  = 0;
    int frames_sent = 0;
    int verdicts    = 0;
    int idle_cycles = 0;
    int status_seen [4] = '{0, 0, 0, 0};
    bit tx_idle      = 1'b1;
    bit rx_idle      = 1'b1;
    bit hold_request = 1'b0;

    analyzer_frame_check_and_ack #(
        .MAX_FRAME (FRAME_LIMIT)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic verdict_t make_verdict(input ack_kind_t ack, input frame_kind_t kind,
                                              input check_status_t status,
                                              input logic [7:0] fn);
        verdict_t v;
        v.ack_kind      = ack;
        v.frame_kind    = kind;
        v.check_status  = status;
        v.function_code = fn;
        return v;
    endfunction

    // Advance the mirrored frame state by one byte; a CR yields a verdict.
    function automatic void step_frame(input logic [7:0] rx, output bit emitted,
                                       output verdict_t v);
        check_status_t status;
        frame_kind_t   kind;
        ack_kind_t     ack;
        logic [7:0]    digit;
        emitted = 1'b0;
        v       = '0;
        if (rx == CH_CR)
        begin
            case (fr_id)
                ID_HEAD:   kind = FRAME_HEAD;
                ID_RESULT: kind = FRAME_RESULT;
                ID_END:    kind = FRAME_END;
                ID_REPEAT: kind = FRAME_REPEAT;
                default:   kind = FRAME_OTHER;
            endcase
            if (!fr_etx)
                status = CHECK_NO_ETX;
            else if (fr_sum == 8'h00)
                status = CHECK_SKIPPED;
            else if (fr_sum == fr_rsum)
                status = CHECK_MATCH;
            else
                status = CHECK_MISMATCH;
            // A failed check always asks for a resend; otherwise the id decides, and a repeat follows the previous ack.
            if (status == CHECK_MISMATCH || status == CHECK_NO_ETX)
            begin
                ack      = ACK_REP;
                prev_ack = ACK_REP;
            end
            else if (kind == FRAME_HEAD || kind == FRAME_RESULT)
            begin
                ack      = ACK_MOR;
                prev_ack = ACK_MOR;
            end
            else if (kind == FRAME_REPEAT)
            begin
                ack = (prev_ack == ACK_MOR) ? ACK_MOR : ACK_REP;
            end
            else
            begin
                ack = ACK_NONE;
            end
            v         = make_verdict(ack, kind, status, fr_fn);
            emitted   = 1'b1;
            fr_pos    = 0;
            fr_sum    = '0;
            fr_etx    = 1'b0;
            fr_digits = 0;
            fr_rsum   = '0;
            fr_id     = '0;
            fr_fn     = '0;
        end
        else if (fr_pos < FRAME_LIMIT)
        begin
            if (fr_pos == 1)
                fr_id = rx;
            if (fr_pos == 2)
                fr_fn = rx;
            if (fr_pos >= 1)
            begin
                if (!fr_etx)
                begin
                    if (fr_pos >= 2 && rx == CH_ETX)
                        fr_etx = 1'b1;
                    else
                        fr_sum = fr_sum + rx;
                end
                else if (fr_digits < 2)
                begin
                    // Letters sit 7 codes above the digits; wrap modulo 256.
                    digit = rx - 8'h30;
                    if (rx > 8'h39)
                        digit = digit - 8'd7;
                    if (fr_digits == 0)
                        fr_rsum = {digit[3:0], 4'h0};
                    else
                        fr_rsum = fr_rsum + digit;
                    fr_digits++;
                end
            end
            fr_pos++;
        end
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom);
        while (b == CH_CR || b == CH_ETX)
            b = 8'($urandom);
        return b;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h37 + 8'(n);
    endfunction

    task automatic add_row(input logic [7:0] rx, input bit pinned = 1'b0,
                           input verdict_t want = '0);
        directed_row_t row;
        row.rx     = rx;
        row.pinned = pinned;
        row.want   = want;
        directed_rows.push_back(row);
    endtask

    // Offer one byte at the falling edge and wait for its handshake.
    task automatic send_byte(input logic [7:0] rx, input bit pinned = 1'b0,
                             input verdict_t want = '0);
        int       gap;
        bit       emitted;
        verdict_t predicted;
        gap = tx_idle ? $urandom_range(0, 4) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = rx;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        step_frame(rx, emitted, predicted);
        if (emitted)
        begin
            verdict_q.push_back(pinned ? want : predicted);
            frames_sent++;
        end
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i]);
    endtask

    // Drop the input and wait until every verdict has been taken.
    task automatic drain_verdicts();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
    endtask

    // Mostly well-formed frames with random content, the rest noise.
    task automatic build_frame();
        int         pick;
        logic [7:0] id;
        logic [7:0] b;
        logic [7:0] sum;
        frame_bytes.delete();
        pick = $urandom_range(0, 99);
        if (pick >= 85)
        begin
            repeat ($urandom_range(0, 8))
                frame_bytes.push_back(8'($urandom));
            frame_bytes.push_back(CH_CR);
            return;
        end
        frame_bytes.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : CH_STX);
        case ($urandom_range(0, 5))
            0:       id = ID_HEAD;
            1:       id = ID_RESULT;
            2:       id = ID_END;
            3, 4:    id = ID_REPEAT;
            default: id = 8'($urandom);
        endcase
        frame_bytes.push_back(id);
        b = plain_byte();
        frame_bytes.push_back(b);
        sum = id + b;
        repeat ($urandom_range(0, 5))
        begin
            b = plain_byte();
            frame_bytes.push_back(b);
            sum = sum + b;
        end
        // Now and then force a zero sum so that the check is skipped.
        if ($urandom_range(0, 9) == 0 && sum != 8'h00)
        begin
            b = 8'h00 - sum;
            if (b != CH_CR && b != CH_ETX)
            begin
                frame_bytes.push_back(b);
                sum = 8'h00;
            end
        end
        if ($urandom_range(0, 9) != 0)
            frame_bytes.push_back(CH_ETX);
        case ($urandom_range(0, 9))
            6:
            begin
                sum = sum + 8'($urandom_range(1, 255));
                frame_bytes.push_back(hex_char(sum[7:4]));
                frame_bytes.push_back(hex_char(sum[3:0]));
            end
            7:
            begin
                frame_bytes.push_back(plain_byte());
                frame_bytes.push_back(plain_byte());
            end
            8:
            begin
                frame_bytes.push_back(hex_char(sum[7:4]));
            end
            9:
            begin
            end
            default:
            begin
                frame_bytes.push_back(hex_char(sum[7:4]));
                frame_bytes.push_back(hex_char(sum[3:0]));
            end
        endcase
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 3))
                frame_bytes.push_back(plain_byte());
        end
        frame_bytes.push_back(CH_CR);
    endtask

    // One frame that runs past the length limit, ETX placed near the boundary.
    task automatic build_overlong_frame();
        int         etx_at;
        logic [7:0] b;
        logic [7:0] sum;
        frame_bytes.delete();
        etx_at = $urandom_range(FRAME_LIMIT - 8, FRAME_LIMIT + 4);
        sum    = ID_RESULT;
        frame_bytes.push_back(CH_STX);
        frame_bytes.push_back(ID_RESULT);
        for (int pos = 2; pos < etx_at; pos++)
        begin
            b = plain_byte();
            frame_bytes.push_back(b);
            if (pos < FRAME_LIMIT)
                sum = sum + b;
        end
        frame_bytes.push_back(CH_ETX);
        frame_bytes.push_back(hex_char(sum[7:4]));
        frame_bytes.push_back(hex_char(sum[3:0]));
        frame_bytes.push_back(CH_ETX);
        frame_bytes.push_back(plain_byte());
        frame_bytes.push_back(CH_CR);
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Stimulus: directed table, random frames with pressure phases, then drain.
    initial
    begin
        int random_target;
        int frame_index;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // A bare CR straight after reset carries neither id nor ETX.
        add_row(CH_CR, 1'b1, make_verdict(ACK_REP, FRAME_OTHER, CHECK_NO_ETX, 8'h00));
        // A header frame whose sum of 0x80 matches its digits.
        add_row(CH_STX);
        add_row(ID_HEAD);
        add_row(8'h44);
        add_row(CH_ETX);
        add_row(8'h38);
        add_row(8'h30);
        add_row(CH_CR, 1'b1, make_verdict(ACK_MOR, FRAME_HEAD, CHECK_MATCH, 8'h44));
        // An end frame whose sum wraps to zero, with its digits missing.
        add_row(CH_STX);
        add_row(ID_END);
        add_row(8'hC6);
        add_row(CH_ETX);
        add_row(CH_CR, 1'b1, make_verdict(ACK_NONE, FRAME_END, CHECK_SKIPPED, 8'hC6));
        // A result frame with a lower-case digit and a trailing extra byte.
        add_row(8'hFF);
        add_row(ID_RESULT);
        add_row(8'h00);
        add_row(CH_ETX);
        add_row(8'h66);
        add_row(8'h46);
        add_row(8'h5A);
        add_row(CH_CR, 1'b1, make_verdict(ACK_REP, FRAME_RESULT, CHECK_MISMATCH, 8'h00));
        // A repeat request after a resend request repeats the resend.
        add_row(CH_STX);
        add_row(ID_REPEAT);
        add_row(8'h41);
        add_row(CH_ETX);
        add_row(8'h38);
        add_row(8'h30);
        add_row(CH_CR, 1'b1, make_verdict(ACK_REP, FRAME_REPEAT, CHECK_MATCH, 8'h41));

        foreach (directed_rows[i])
            send_byte(directed_rows[i].rx, directed_rows[i].pinned, directed_rows[i].want);
        drain_verdicts();

        random_target = bytes_sent + RANDOM_ITEMS;
        frame_index   = 0;
        while (bytes_sent < random_target)
        begin
            // Change the idling pattern every so often, with some gap-free stretches.
            if (frame_index % 12 == 0)
            begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            if (frame_index == 20)
            begin
                drain_verdicts();
            end
            if (frame_index == 30)
            begin
                // Hold the output back while frames keep coming at full rate.
                hold_request = 1'b1;
                tx_idle      = 1'b0;
                repeat (8)
                begin
                    build_frame();
                    send_frame();
                end
            end
            if (frame_index == 50)
                build_overlong_frame();
            else
                build_frame();
            send_frame();
            frame_index++;
        end

        drain_verdicts();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("tb: %0d bytes in %0d frames, %0d verdicts checked, one overlong frame",
                 bytes_sent, frames_sent, verdicts);
        $display("tb: status match/skipped/mismatch/no-ETX %0d/%0d/%0d/%0d, output held %0d cycles",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3], HOLD_CYCLES);
        if (errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    // Verdict receiver: random back-pressure plus one long hold-off on request.
    initial
    begin
        int low;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            low = rx_idle ? $urandom_range(0, 4) : 0;
            if (hold_request)
            begin
                low          = low + HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (low != 0)
            begin
                m_tready = 1'b0;
                repeat (low) @(negedge clk);
            end
            m_tready = 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // Compare each verdict taken with the oldest one expected.
    always @(posedge clk)
    begin
        verdict_t seen;
        verdict_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen = verdict_t'(m_tdata[14:0]);
            if (verdict_q.size() == 0)
            begin
                $display("%0t: verdict expected none got %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                want = verdict_q.pop_front();
                compare_field("ack_kind", 8'(want.ack_kind), 8'(seen.ack_kind));
                compare_field("frame_kind", 8'(want.frame_kind), 8'(seen.frame_kind));
                compare_field("check_status", 8'(want.check_status), 8'(seen.check_status));
                compare_field("function_code", want.function_code, seen.function_code);
                compare_field("pad bit", 8'h00, 8'(m_tdata[15]));
            end
            if (!$isunknown(seen.check_status))
                status_seen[seen.check_status]++;
            verdicts++;
        end
    end

    // Watchdog: end the run when no item moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles, %0d verdicts outstanding",
                         $time, STALL_LIMIT, verdict_q.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

endmodule
